[rtl/core/dap_pkg.sv]
// ----------------------------------------------------------------------------
// dap_pkg
// Types and constants shared by the demand proportional allocator modules.
// ----------------------------------------------------------------------------
package dap_pkg;

  localparam int NUM_TARGETS = 5;
  localparam int DATA_W      = 16;
  localparam int IDX_W       = $clog2(NUM_TARGETS);
  // Sum of all demands never overflows this width.
  localparam int SUM_W       = DATA_W + $clog2(NUM_TARGETS);
  localparam int CNT_W       = $clog2(DATA_W + 1);

  typedef struct packed {
    logic [DATA_W-1:0] batch_size;
    logic [DATA_W-1:0] demand_0;
    logic [DATA_W-1:0] demand_1;
    logic [DATA_W-1:0] demand_2;
    logic [DATA_W-1:0] demand_3;
    logic [DATA_W-1:0] demand_4;
  } in_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] share_0;
    logic [DATA_W-1:0] share_1;
    logic [DATA_W-1:0] share_2;
    logic [DATA_W-1:0] share_3;
    logic [DATA_W-1:0] share_4;
  } out_beat_t;

  // Request to the serial multiply-divide unit.
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] batch;
    logic [DATA_W-1:0] dem;
    logic [SUM_W-1:0]  sum;
  } muldiv_req_t;

  // Response: done pulses for one cycle, quot and rem hold until next start.
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
    logic [SUM_W-1:0]  rem;
  } muldiv_resp_t;

endpackage

[rtl/core/dap_muldiv.sv]
// ----------------------------------------------------------------------------
// dap_muldiv
// Bit-serial floor(batch * dem / sum): one batch bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module dap_muldiv (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dap_pkg::muldiv_req_t  req_i,
  output dap_pkg::muldiv_resp_t resp_o
);

  localparam int DW = dap_pkg::DATA_W;
  localparam int SW = dap_pkg::SUM_W;
  localparam int CW = dap_pkg::CNT_W;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [DW-1:0] bsh_q, bsh_d;
  logic [DW-1:0] dem_q, dem_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [SW-1:0] acc_q, acc_d;
  logic [DW-1:0] quot_q, quot_d;

  logic [SW+1:0] trial;
  logic [SW+1:0] sum1;
  logic [SW+1:0] sum2;
  logic [1:0]    digit;
  logic [SW+1:0] trial_red;

  // Remainder stays below sum, so the trial stays below three times sum.
  always_comb begin
    sum1  = {2'b00, sum_q};
    sum2  = {1'b0, sum_q, 1'b0};
    trial = {1'b0, acc_q, 1'b0} + (bsh_q[DW-1] ? {{(SW+2-DW){1'b0}}, dem_q} : '0);
    if (trial >= sum2) begin
      digit     = 2'd2;
      trial_red = trial - sum2;
    end else if (trial >= sum1) begin
      digit     = 2'd1;
      trial_red = trial - sum1;
    end else begin
      digit     = 2'd0;
      trial_red = trial;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    bsh_d  = bsh_q;
    dem_d  = dem_q;
    sum_d  = sum_q;
    acc_d  = acc_q;
    quot_d = quot_q;
    if (req_i.start) begin
      cnt_d  = CW'(DW);
      bsh_d  = req_i.batch;
      dem_d  = req_i.dem;
      sum_d  = req_i.sum;
      acc_d  = '0;
      quot_d = '0;
    end else if (cnt_q != '0) begin
      // Advance one batch bit.
      cnt_d  = cnt_q - CW'(1);
      bsh_d  = {bsh_q[DW-2:0], 1'b0};
      acc_d  = trial_red[SW-1:0];
      quot_d = {quot_q[DW-2:0], 1'b0} + {{(DW-2){1'b0}}, digit};
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bsh_q  <= bsh_d;
    dem_q  <= dem_d;
    sum_q  <= sum_d;
    acc_q  <= acc_d;
    quot_q <= quot_d;
  end

  assign resp_o.done = done_q;
  assign resp_o.quot = quot_q;
  assign resp_o.rem  = acc_q;

endmodule

[rtl/core/demand_proportional_allocator.sv]
// ----------------------------------------------------------------------------
// demand_proportional_allocator
// Splits a batch of units among five targets in proportion to their demand.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one beat holding the batch size
// and five demand counts. Output channel: out_valid_o / out_stall_i carry one
// beat holding the five shares. Every input beat yields exactly one output beat.
// A beat moves on a rising edge where valid is high and stall is low.
//
// Timing: the demands are summed one per cycle. Each target's proportional
// share comes from one bit-serial multiply-divide unit that consumes one batch
// bit per cycle, with a launch and a handoff per target. Leftover units (at
// most four) are handed out by a serial max scan, one scan per unit. The shares
// then move to the output register, and the next beat can be taken in the
// following cycle, so a beat is not taken before the last one is through.
// With all demands zero one division gives the even split. The shared divider
// sets the rate.
//
// in_stall_o is high from acceptance until the shares are moved into the output
// register. The output register lets the next item start while a result waits
// on a stalled receiver; the result beat holds steady until taken.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module demand_proportional_allocator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dap_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dap_pkg::out_beat_t out_data_o
);

  localparam int N  = dap_pkg::NUM_TARGETS;
  localparam int DW = dap_pkg::DATA_W;
  localparam int SW = dap_pkg::SUM_W;
  localparam int IW = dap_pkg::IDX_W;
  localparam logic [IW-1:0] LAST = IW'(N - 1);

  // Sequencer codes.
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SUM       = 3'd1;
  localparam logic [2:0] ST_LAUNCH    = 3'd2;
  localparam logic [2:0] ST_WAIT      = 3'd3;
  localparam logic [2:0] ST_SCAN_INIT = 3'd4;
  localparam logic [2:0] ST_SCAN      = 3'd5;
  localparam logic [2:0] ST_COMMIT    = 3'd6;
  localparam logic [2:0] ST_FINISH    = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] best_q, best_d;
  logic [DW-1:0] best_val_q, best_val_d;
  logic          zero_q, zero_d;
  logic [DW-1:0] batch_q, batch_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [DW-1:0] left_q, left_d;
  logic [DW-1:0] dem_q   [N];
  logic [DW-1:0] dem_d   [N];
  logic [DW-1:0] share_q [N];
  logic [DW-1:0] share_d [N];
  logic               out_valid_q, out_valid_d;
  dap_pkg::out_beat_t out_data_q, out_data_d;

  dap_pkg::muldiv_req_t  md_req;
  dap_pkg::muldiv_resp_t md_resp;

  logic [SW-1:0] sum_next;
  logic [DW-1:0] left_next;
  logic          out_load;

  dap_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .resp_o (md_resp)
  );

  // With no demand at all, divide the batch by the target count instead.
  always_comb begin
    md_req.start = (state_q == ST_LAUNCH);
    md_req.batch = batch_q;
    md_req.dem   = zero_q ? DW'(1) : dem_q[idx_q];
    md_req.sum   = zero_q ? SW'(N) : sum_q;
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    best_d     = best_q;
    best_val_d = best_val_q;
    zero_d     = zero_q;
    batch_d    = batch_q;
    sum_d      = sum_q;
    left_d     = left_q;
    dem_d      = dem_q;
    share_d    = share_q;
    out_load   = 1'b0;
    sum_next   = sum_q + {{(SW-DW){1'b0}}, dem_q[idx_q]};
    left_next  = left_q - md_resp.quot;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          batch_d  = in_data_i.batch_size;
          dem_d[0] = in_data_i.demand_0;
          dem_d[1] = in_data_i.demand_1;
          dem_d[2] = in_data_i.demand_2;
          dem_d[3] = in_data_i.demand_3;
          dem_d[4] = in_data_i.demand_4;
          sum_d    = '0;
          idx_d    = '0;
          state_d  = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_d = sum_next;
        if (idx_q == LAST) begin
          idx_d   = '0;
          zero_d  = (sum_next == '0);
          left_d  = batch_q;
          state_d = ST_LAUNCH;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_LAUNCH: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (md_resp.done) begin
          if (zero_q) begin
            // Even split: the first rem targets get one extra unit.
            for (int t = 0; t < N; t++) begin
              share_d[t] = md_resp.quot + ((SW'(t) < md_resp.rem) ? DW'(1) : DW'(0));
            end
            state_d = ST_FINISH;
          end else begin
            share_d[idx_q] = md_resp.quot;
            left_d         = left_next;
            if (idx_q == LAST) begin
              state_d = (left_next == '0) ? ST_FINISH : ST_SCAN_INIT;
            end else begin
              idx_d   = idx_q + IW'(1);
              state_d = ST_LAUNCH;
            end
          end
        end
      end
      ST_SCAN_INIT: begin
        best_d     = '0;
        best_val_d = dem_q[0];
        idx_d      = IW'(1);
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        // Strictly greater keeps the lowest index on ties.
        if (dem_q[idx_q] > best_val_q) begin
          best_d     = idx_q;
          best_val_d = dem_q[idx_q];
        end
        if (idx_q == LAST) begin
          state_d = ST_COMMIT;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_COMMIT: begin
        share_d[best_q] = share_q[best_q] + DW'(1);
        if (best_val_q != '0) begin
          dem_d[best_q] = best_val_q - DW'(1);
        end
        left_d  = left_q - DW'(1);
        state_d = (left_q == DW'(1)) ? ST_FINISH : ST_SCAN_INIT;
      end
      ST_FINISH: begin
        // Hand the shares over once the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d        = 1'b1;
      out_data_d.share_0 = share_q[0];
      out_data_d.share_1 = share_q[1];
      out_data_d.share_2 = share_q[2];
      out_data_d.share_3 = share_q[3];
      out_data_d.share_4 = share_q[4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_val_q <= best_val_d;
    zero_q     <= zero_d;
    batch_q    <= batch_d;
    sum_q      <= sum_d;
    left_q     <= left_d;
    dem_q      <= dem_d;
    share_q    <= share_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The divider only finishes while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_resp.done |-> (state_q == ST_WAIT))
    else $error("divider finished outside the wait state");

  // Never hand out a leftover unit when none remain.
  a_commit_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT) |-> (left_q != '0))
    else $error("leftover unit committed with nothing left");

  // An accepted beat starts the demand sum and closes the input.
  a_accept_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && state_q == ST_SUM))
    else $error("accepted beat did not start the sum");

  // A finished item waits while the output register is still occupied.
  a_finish_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_valid_q && out_stall_i) |=> (state_q == ST_FINISH))
    else $error("result dropped while output register was full");

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Demand proportional allocator testbench
// Drives batch and demand beats through the allocator, predicts the five
// shares of every accepted beat and compares each returned share beat against
// the prediction, under several mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT = dap_pkg::NUM_TARGETS;
  localparam int DW = dap_pkg::DATA_W;

  // Random beats per flow-control phase; four phases follow the directed rows.
  localparam int PHASE_BEATS     = 132;
  // Length of the long output hold that backs the block up into its input.
  localparam int HOLD_OFF_CYCLES = 500;
  // Settling time after the last share beat: longer than one worst-case item.
  localparam int DRAIN_CYCLES    = 200;
  localparam int REPORT_LIMIT    = 10;

  // One row of the directed table. Where known is set, want is the share beat
  // read straight off the rules; otherwise the predictor supplies it.
  typedef struct {
    dap_pkg::in_beat_t  stim;
    bit                 known;
    dap_pkg::out_beat_t want;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  dap_pkg::in_beat_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  dap_pkg::out_beat_t out_data_o;

  // Flow-control knobs. idle_pct is only read by the sending process; stall_pct
  // and hold_off are read by the stall driver, so update them with NBAs.
  int   idle_pct;
  int   stall_pct;
  logic hold_off    = 1'b0;
  logic pressure_go = 1'b0;

  // Share beats owed by the block, oldest first.
  dap_pkg::out_beat_t shares_due[$];

  int beats_sent;
  int even_splits;
  int shares_checked;
  int fault_count;

  demand_proportional_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Share predictor.
  // With any demand present, every target first takes floor(batch * demand /
  // total demand). The few units this leaves go one at a time to the target
  // whose working demand is largest (lowest index on a tie), and that working
  // demand drops by one while positive. With no demand anywhere, split evenly
  // and give the remainder to the lowest targets.
  // --------------------------------------------------------------------------
  function automatic dap_pkg::out_beat_t apportion(dap_pkg::in_beat_t b);
    longint unsigned    dem   [NT];
    longint unsigned    work  [NT];
    longint unsigned    share [NT];
    longint unsigned    batch;
    longint unsigned    total;
    longint unsigned    handed;
    longint unsigned    spare;
    int                 best;
    int                 t;
    dap_pkg::out_beat_t r;

    batch  = b.batch_size;
    dem    = '{b.demand_0, b.demand_1, b.demand_2, b.demand_3, b.demand_4};
    total  = 0;
    handed = 0;
    for (t = 0; t < NT; t++) total += dem[t];

    if (total == 0) begin
      for (t = 0; t < NT; t++)
        share[t] = batch / NT + ((t < batch % NT) ? 1 : 0);
    end else begin
      for (t = 0; t < NT; t++) begin
        share[t] = (batch * dem[t]) / total;
        handed  += share[t];
        work[t]  = dem[t];
      end
      spare = (handed <= batch) ? batch - handed : 0;
      while (spare > 0) begin
        best = 0;
        for (t = 1; t < NT; t++)
          if (work[t] > work[best]) best = t;
        share[best]++;
        if (work[best] > 0) work[best]--;
        spare--;
      end
    end

    r.share_0 = 16'(share[0]);
    r.share_1 = 16'(share[1]);
    r.share_2 = 16'(share[2]);
    r.share_3 = 16'(share[3]);
    r.share_4 = 16'(share[4]);
    return r;
  endfunction

  function automatic dap_pkg::in_beat_t beat_in(int batch, int d0, int d1, int d2, int d3,
                                                int d4);
    return {16'(batch), 16'(d0), 16'(d1), 16'(d2), 16'(d3), 16'(d4)};
  endfunction

  function automatic dap_pkg::out_beat_t beat_out(int s0, int s1, int s2, int s3, int s4);
    return {16'(s0), 16'(s1), 16'(s2), 16'(s3), 16'(s4)};
  endfunction

  // Pick one demand: zero often (so leftovers and even splits stay common),
  // small counts that make ties, full-range values, and the top value.
  function automatic logic [DW-1:0] draw_demand();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick <= 2) return '0;
    if (pick <= 4) return DW'($urandom_range(8, 1));
    if (pick <= 8) return DW'($urandom_range(65535));
    return '1;
  endfunction

  function automatic dap_pkg::in_beat_t draw_batch();
    dap_pkg::in_beat_t b;
    int unsigned       pick;
    pick = $urandom_range(9);
    if (pick <= 3)      b.batch_size = DW'($urandom_range(20));
    else if (pick <= 8) b.batch_size = DW'($urandom_range(65535));
    else                b.batch_size = '1;
    // About one beat in twelve carries no demand at all.
    if ($urandom_range(11) == 0) begin
      b.demand_0 = '0;
      b.demand_1 = '0;
      b.demand_2 = '0;
      b.demand_3 = '0;
      b.demand_4 = '0;
    end else begin
      b.demand_0 = draw_demand();
      b.demand_1 = draw_demand();
      b.demand_2 = draw_demand();
      b.demand_3 = draw_demand();
      b.demand_4 = draw_demand();
    end
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Insert random idle cycles, then offer the beat and hold it until
  // an edge sees valid high with stall low. Queue the owed shares on accept.
  // valid gets a single NBA per time step: either kept high for the next beat
  // or dropped for a gap, never both.
  // --------------------------------------------------------------------------
  task automatic send_batch(dap_pkg::in_beat_t b, dap_pkg::out_beat_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    shares_due.push_back(want);
    beats_sent++;
    if ((b.demand_0 | b.demand_1 | b.demand_2 | b.demand_3 | b.demand_4) == '0)
      even_splits++;
  endtask

  task automatic check_share(string field, int beat, logic [DW-1:0] want,
                             logic [DW-1:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
        $display("allocation %0d %s: expected %0d, got %0d", beat, field, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver stall. Random stalls at stall_pct, forced high for the whole
  // output hold, low during reset.
  // --------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      out_stall_i <= rst_ni && (hold_off || ($urandom_range(99) < stall_pct));
    end
  end

  // Long output hold, counted here so the sender keeps offering beats while
  // the block's output register and datapath fill and its input stalls.
  initial begin
    @(posedge pressure_go);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Share monitor. Every share beat taken must match the oldest owed one,
  // field by field; a beat with nothing owed is a failure on its own.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    dap_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (shares_due.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("share beat with nothing owed: %h", out_data_o);
      end else begin
        want = shares_due.pop_front();
        check_share("share_0", shares_checked, want.share_0, out_data_o.share_0);
        check_share("share_1", shares_checked, want.share_1, out_data_o.share_1);
        check_share("share_2", shares_checked, want.share_2, out_data_o.share_2);
        check_share("share_3", shares_checked, want.share_3, out_data_o.share_3);
        check_share("share_4", shares_checked, want.share_4, out_data_o.share_4);
        shares_checked++;
      end
    end
  end

  // Run limit: far above the slowest correct run.
  initial begin
    #4_000_000;
    $display("timed out with %0d allocations outstanding", shares_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, then four random phases.
  // --------------------------------------------------------------------------
  initial begin
    plan_row_t         plan[$];
    dap_pkg::in_beat_t b;
    int                phase;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    beats_sent     = 0;
    even_splits    = 0;
    shares_checked = 0;
    fault_count    = 0;

    // No demand: even split, remainder to the lowest targets.
    plan.push_back('{beat_in(0, 0, 0, 0, 0, 0), 1'b1, beat_out(0, 0, 0, 0, 0)});
    plan.push_back('{beat_in(7, 0, 0, 0, 0, 0), 1'b1, beat_out(2, 2, 1, 1, 1)});
    plan.push_back('{beat_in(4, 0, 0, 0, 0, 0), 1'b1, beat_out(1, 1, 1, 1, 0)});
    plan.push_back('{beat_in(5, 0, 0, 0, 0, 0), 1'b1, beat_out(1, 1, 1, 1, 1)});
    plan.push_back('{beat_in(65535, 0, 0, 0, 0, 0), 1'b1,
                     beat_out(13107, 13107, 13107, 13107, 13107)});
    // Extremes of batch and demand.
    plan.push_back('{beat_in(0, 65535, 65535, 65535, 65535, 65535), 1'b1,
                     beat_out(0, 0, 0, 0, 0)});
    plan.push_back('{beat_in(65535, 65535, 65535, 65535, 65535, 65535), 1'b1,
                     beat_out(13107, 13107, 13107, 13107, 13107)});
    plan.push_back('{beat_in(65535, 0, 0, 1, 0, 0), 1'b1, beat_out(0, 0, 65535, 0, 0)});
    plan.push_back('{beat_in(65535, 65535, 0, 0, 0, 0), 1'b1, beat_out(65535, 0, 0, 0, 0)});
    plan.push_back('{beat_in(1, 0, 0, 0, 0, 65535), 1'b1, beat_out(0, 0, 0, 0, 1)});
    // Four leftover units, then one, on equal demands: lowest indices win the ties.
    plan.push_back('{beat_in(4, 1, 1, 1, 1, 1), 1'b1, beat_out(1, 1, 1, 1, 0)});
    plan.push_back('{beat_in(1, 1, 1, 1, 1, 1), 1'b1, beat_out(1, 0, 0, 0, 0)});
    // Leftover hand-out with shrinking working demands and mixed patterns.
    plan.push_back('{beat_in(9, 2, 2, 2, 2, 2), 1'b0, '0});
    plan.push_back('{beat_in(10, 3, 3, 3, 1, 1), 1'b0, '0});
    plan.push_back('{beat_in(3, 1, 0, 0, 0, 1), 1'b0, '0});
    plan.push_back('{beat_in(3, 0, 0, 7, 7, 0), 1'b0, '0});
    plan.push_back('{beat_in(65535, 1, 2, 3, 4, 5), 1'b0, '0});
    plan.push_back('{beat_in(65535, 65535, 1, 1, 1, 1), 1'b0, '0});
    plan.push_back('{beat_in(12345, 1, 1, 0, 0, 65535), 1'b0, '0});
    plan.push_back('{beat_in(65534, 16'h5555, 16'haaaa, 16'hffff, 16'h0001, 16'h8000),
                     1'b0, '0});
    plan.push_back('{beat_in(16'haaaa, 16'haaaa, 16'h5555, 0, 16'h5555, 16'haaaa),
                     1'b0, '0});
    plan.push_back('{beat_in(16'h5555, 16'h8001, 16'h7ffe, 16'h0100, 16'h00ff, 16'h0002),
                     1'b0, '0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i])
      send_batch(plan[i].stim, plan[i].known ? plan[i].want : apportion(plan[i].stim));

    // Phase 0 runs free except for the long output hold; then sender gaps,
    // receiver stalls, and both together.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct     = 0;
          stall_pct   <= 0;
          pressure_go <= 1'b1;
        end
        1: begin
          idle_pct   = 57;
          stall_pct <= 0;
        end
        2: begin
          idle_pct   = 0;
          stall_pct <= 57;
        end
        default: begin
          idle_pct   = 28;
          stall_pct <= 28;
        end
      endcase
      repeat (PHASE_BEATS) begin
        b = draw_batch();
        send_batch(b, apportion(b));
      end
    end
    in_valid_i <= 1'b0;

    // Drain owed shares, then watch for stray beats.
    while (shares_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d batches (%0d with no demand), compared %0d share beats, %0d faults.",
             beats_sent, even_splits, shares_checked, fault_count);
    $display("Flow control: free running, sender gaps, receiver stalls, both, and one %0d-cycle output hold.",
             HOLD_OFF_CYCLES);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/dap_pkg.sv
rtl/core/dap_muldiv.sv
rtl/core/demand_proportional_allocator.sv
tb/sv/testbench.sv
